>>> src/cdec_pkg.sv
`default_nettype none

package cdec_pkg;

	localparam int unsigned PIXEL_W    = 8;
	localparam int unsigned THRESH_W   = 8;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned CROP_W     = 13;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - CROP_W;
	localparam int unsigned CNT_W      = 10;
	localparam int unsigned AVG_W      = 8;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [AVG_W-1:0] AVG_MAX   = '1;

	localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd20;
	localparam logic [DIM_W-1:0]    WIDTH_RST     = 13'd1024;
	localparam logic [DIM_W-1:0]    HEIGHT_RST    = 13'd768;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_SCAN_START,
		ST_SCAN_RD,
		ST_SCAN_NUM,
		ST_SCAN_DIV,
		ST_SCAN_EVAL,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

>>> src/cdec_col_mem.sv
`default_nettype none

module cdec_col_mem #(
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = 12
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ADDR_W-1:0]           wr_addr,
	input  wire logic [cdec_pkg::CNT_W-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0]           rd_addr,
	output logic      [cdec_pkg::CNT_W-1:0]  rd_data
);

	logic [cdec_pkg::CNT_W-1:0] mem_q [DEPTH];
	logic [cdec_pkg::CNT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> src/cdec_avg_div.sv
`default_nettype none

module cdec_avg_div #(
	parameter int unsigned DIV_W = 13
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cdec_pkg::CNT_W-1:0]  count,
	input  wire logic [DIV_W-1:0]            divisor,
	output logic                             done,
	output logic      [cdec_pkg::AVG_W-1:0]  quotient
);

	localparam int unsigned NUM_W  = cdec_pkg::CNT_W + cdec_pkg::AVG_W;
	localparam int unsigned DSH_W  = DIV_W + cdec_pkg::AVG_W;
	localparam int unsigned XW     = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int unsigned STEP_W = $clog2(cdec_pkg::AVG_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(cdec_pkg::AVG_W - 1);

	logic [XW-1:0]                 num;
	logic [XW-1:0]                 lim;
	logic                          sat;
	logic [XW-1:0]                 rem_q;
	logic [XW-1:0]                 dsh_q;
	logic [cdec_pkg::AVG_W-1:0]    quo_q;
	logic [STEP_W-1:0]             step_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          fits;

	// The numerator is count*255, formed as count*256 - count.
	assign num  = (XW'(count) << cdec_pkg::AVG_W) - XW'(count);
	assign lim  = XW'(divisor) << cdec_pkg::AVG_W;
	assign sat  = (num >= lim);
	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= XW'(divisor) << (cdec_pkg::AVG_W - 1);
			quo_q <= sat ? cdec_pkg::AVG_MAX : '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[cdec_pkg::AVG_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> src/column_density_edge_crop_unit.sv
`default_nettype none

// Finds how many columns to keep from the left of a grayscale frame. Pixels
// enter on the s_axis side in raster order, one word per pixel, with tuser
// high on the first pixel of a frame; a pixel strictly above the threshold
// counts as bright, and on every ROW_STEP-th row a per-column bright count is
// kept in a column memory with a read-modify-write path that takes one pixel
// per cycle. After the last pixel of a frame the columns are scanned from the
// right edge down to MIN_CROP, and one word with the crop width and the
// edge-found flag leaves on the m_axis side. Each column average is formed
// by a bit-per-cycle divider that returns the full-scale value without
// dividing when the average saturates. Each scan is followed by a clearing
// pass over the whole column memory; the same pass runs after reset, and a
// frame start that arrives while counts of an unfinished frame are stored
// also waits for one. Pixels are not taken during the scan and the clearing
// pass; configuration writes are taken at any time.

module column_density_edge_crop_unit #(
	parameter int unsigned MAX_WIDTH     = 4096,
	parameter int unsigned MAX_HEIGHT    = 4096,
	parameter int unsigned ROW_STEP      = 5,
	parameter int unsigned WINDOW_LENGTH = 20,
	parameter int unsigned MIN_CROP      = 200
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [cdec_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [cdec_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [cdec_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready,

	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [cdec_pkg::PIXEL_W-1:0]        s_axis_tdata,   // [7:0] pixel
	input  wire logic                                s_axis_tuser,   // [0] frame_start

	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic      [cdec_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [12:0] crop_width
	output logic                                     m_axis_tuser    // [0] edge_found
);

	localparam int unsigned COL_W    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned ROW_W    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned ADDR_W   = $clog2(MAX_WIDTH);
	localparam int unsigned PH_W     = (ROW_STEP > 1) ? $clog2(ROW_STEP) : 1;
	localparam int unsigned HIST_LEN = WINDOW_LENGTH - 1;
	localparam int unsigned SUM_W    = $clog2(HIST_LEN * 255 + 1);
	localparam int unsigned EDGE_GAP = 2 * WINDOW_LENGTH;
	localparam logic [PH_W-1:0]   PH_LAST  = PH_W'(ROW_STEP - 1);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_WIDTH - 1);

	// Configuration registers.
	logic [cdec_pkg::THRESH_W-1:0] thr_q;
	logic [cdec_pkg::DIM_W-1:0]    fw_q;
	logic [cdec_pkg::DIM_W-1:0]    fh_q;
	logic                          cfg_wr;
	logic [1:0]                    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= cdec_pkg::THRESHOLD_RST;
			fw_q  <= cdec_pkg::WIDTH_RST;
			fh_q  <= cdec_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				cdec_pkg::REG_THRESHOLD: begin
					thr_q <= pwdata[cdec_pkg::THRESH_W-1:0];
				end
				cdec_pkg::REG_WIDTH: begin
					fw_q <= pwdata[cdec_pkg::DIM_W-1:0];
				end
				cdec_pkg::REG_HEIGHT: begin
					fh_q <= pwdata[cdec_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			cdec_pkg::REG_THRESHOLD: prdata = cdec_pkg::APB_DATA_W'(thr_q);
			cdec_pkg::REG_WIDTH:     prdata = cdec_pkg::APB_DATA_W'(fw_q);
			cdec_pkg::REG_HEIGHT:    prdata = cdec_pkg::APB_DATA_W'(fh_q);
			default:                 prdata = '0;
		endcase
	end

	// Frame size as used, saturated to the supported range, with zero taken as one.
	logic [31:0]      fw_ext;
	logic [31:0]      fh_ext;
	logic [COL_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;

	assign fw_ext = 32'(fw_q);
	assign fh_ext = 32'(fh_q);

	always_comb begin
		if (fw_ext == 32'd0) begin
			w_eff = COL_W'(1);
		end else if (fw_ext > 32'(MAX_WIDTH)) begin
			w_eff = COL_W'(MAX_WIDTH);
		end else begin
			w_eff = COL_W'(fw_ext);
		end
		if (fh_ext == 32'd0) begin
			h_eff = ROW_W'(1);
		end else if (fh_ext > 32'(MAX_HEIGHT)) begin
			h_eff = ROW_W'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_W'(fh_ext);
		end
	end

	// Control state.
	cdec_pkg::state_t state_q;
	cdec_pkg::state_t state_d;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [PH_W-1:0]   ph_q;
	logic [ROW_W-1:0]  nrow_q;
	logic              dirty_q;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;

	logic [cdec_pkg::CROP_W-1:0] out_crop_q;
	logic                        out_found_q;

	// Position tracking for one accepted pixel.
	logic              acc;
	logic              start;
	logic [ROW_W-1:0]  r_t;
	logic [COL_W-1:0]  c_t;
	logic [PH_W-1:0]   p_t;
	logic [ROW_W-1:0]  n_t;
	logic              live_t;
	logic              sample;
	logic              last;
	logic              pos_upd;
	logic [ADDR_W-1:0] pix_addr;

	assign acc   = s_axis_tvalid && s_axis_tready;
	assign start = s_axis_tuser;

	always_comb begin
		r_t      = start ? '0 : row_q;
		c_t      = start ? '0 : col_q;
		p_t      = start ? '0 : ph_q;
		n_t      = start ? '0 : nrow_q;
		live_t   = 1'b0;
		sample   = 1'b0;
		last     = 1'b0;
		pix_addr = '0;
		pos_upd  = start || (row_q < h_eff);
		if (pos_upd) begin
			live_t = 1'b1;
			if (c_t >= w_eff) begin
				c_t = '0;
				if (p_t == '0) begin
					n_t = n_t + 1'b1;
				end
				r_t = r_t + 1'b1;
				p_t = (p_t == PH_LAST) ? '0 : p_t + 1'b1;
				if (r_t >= h_eff) begin
					live_t = 1'b0;
				end
			end
			if (live_t) begin
				sample   = (p_t == '0) && (s_axis_tdata > thr_q);
				pix_addr = c_t[ADDR_W-1:0];
				c_t      = c_t + 1'b1;
				if (c_t >= w_eff) begin
					c_t = '0;
					if (p_t == '0) begin
						n_t = n_t + 1'b1;
					end
					r_t = r_t + 1'b1;
					p_t = (p_t == PH_LAST) ? '0 : p_t + 1'b1;
				end
				last = (r_t >= h_eff);
			end
		end
	end

	// Column count read-modify-write.
	logic                       wr_s1;
	logic [ADDR_W-1:0]          addr_s1;
	logic                       fwd_hit_s1;
	logic [cdec_pkg::CNT_W-1:0] fwd_data_s1;
	logic [cdec_pkg::CNT_W-1:0] rd_data;
	logic [cdec_pkg::CNT_W-1:0] cnt_base;
	logic [cdec_pkg::CNT_W-1:0] cnt_inc;

	logic                       mem_wr_en;
	logic [ADDR_W-1:0]          mem_wr_addr;
	logic [cdec_pkg::CNT_W-1:0] mem_wr_data;
	logic [ADDR_W-1:0]          mem_rd_addr;

	// Scan state.
	logic [COL_W-1:0]           sc_q;
	logic [COL_W-1:0]           scol;
	logic [SUM_W-1:0]           sum_q;
	logic [cdec_pkg::AVG_W-1:0] hist_q [HIST_LEN];
	logic [COL_W-1:0]           crop_q;
	logic                       found_q;
	logic                       div_start;
	logic                       div_done;
	logic [cdec_pkg::AVG_W-1:0] avg;
	logic [ROW_W-1:0]           divisor;
	logic                       near_ok;
	logic                       hit;
	logic                       more;
	logic                       wide;

	assign cnt_base = fwd_hit_s1 ? fwd_data_s1 : rd_data;
	assign cnt_inc  = (cnt_base == cdec_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;

	assign mem_wr_en   = wr_s1 || (state_q == cdec_pkg::ST_CLEAR);
	assign mem_wr_addr = wr_s1 ? addr_s1 : clr_q;
	assign mem_wr_data = wr_s1 ? cnt_inc : '0;
	assign mem_rd_addr = (state_q == cdec_pkg::ST_RUN) ? pix_addr : scol[ADDR_W-1:0];

	cdec_col_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (ADDR_W)
	) u_col_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	assign divisor = (nrow_q == '0) ? ROW_W'(1) : nrow_q;

	cdec_avg_div #(
		.DIV_W (ROW_W)
	) u_avg_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.count    (rd_data),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (avg)
	);

	assign scol    = sc_q - 1'b1;
	assign near_ok = (32'(scol) + 32'(EDGE_GAP)) < 32'(w_eff);
	assign hit     = near_ok && ((SUM_W'(HIST_LEN) * SUM_W'(avg)) > sum_q);
	assign more    = 32'(scol) > 32'(MIN_CROP);
	assign wide    = 32'(w_eff) > 32'(MIN_CROP);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		case (state_q)
			cdec_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = cdec_pkg::ST_RUN;
				end
			end
			cdec_pkg::ST_RUN: begin
				s_axis_tready = !(start && dirty_q);
				if (s_axis_tvalid && start && dirty_q) begin
					state_d = cdec_pkg::ST_CLEAR;
				end else if (acc && last) begin
					state_d = cdec_pkg::ST_SCAN_START;
				end
			end
			cdec_pkg::ST_SCAN_START: begin
				state_d = wide ? cdec_pkg::ST_SCAN_RD : cdec_pkg::ST_RESULT;
			end
			cdec_pkg::ST_SCAN_RD: begin
				state_d = cdec_pkg::ST_SCAN_NUM;
			end
			cdec_pkg::ST_SCAN_NUM: begin
				div_start = 1'b1;
				state_d   = cdec_pkg::ST_SCAN_DIV;
			end
			cdec_pkg::ST_SCAN_DIV: begin
				if (div_done) begin
					state_d = cdec_pkg::ST_SCAN_EVAL;
				end
			end
			cdec_pkg::ST_SCAN_EVAL: begin
				if (hit || !more) begin
					state_d = cdec_pkg::ST_RESULT;
				end else begin
					state_d = cdec_pkg::ST_SCAN_RD;
				end
			end
			cdec_pkg::ST_RESULT: begin
				if (!out_valid_q) begin
					state_d = cdec_pkg::ST_CLEAR;
				end
			end
			default: begin
				state_d = cdec_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdec_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			ph_q        <= '0;
			nrow_q      <= '0;
			dirty_q     <= 1'b1;
			clr_q       <= '0;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_s1 <= acc && sample;
			if (acc && pos_upd) begin
				row_q  <= r_t;
				col_q  <= c_t;
				ph_q   <= p_t;
				nrow_q <= n_t;
			end
			if (acc && sample) begin
				dirty_q <= 1'b1;
			end
			if (state_q == cdec_pkg::ST_CLEAR) begin
				clr_q <= (clr_q == CLR_LAST) ? '0 : clr_q + 1'b1;
				if (clr_q == CLR_LAST) begin
					dirty_q <= 1'b0;
				end
			end
			if (state_q == cdec_pkg::ST_RESULT && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A write lands in the cycle in which the next pixel reads, so the new
	// count is forwarded when both fall on the same column.
	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1 <= pix_addr;
		end
		fwd_hit_s1  <= wr_s1 && (addr_s1 == pix_addr);
		fwd_data_s1 <= cnt_inc;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cdec_pkg::ST_SCAN_START: begin
				sc_q    <= w_eff;
				sum_q   <= '0;
				crop_q  <= w_eff;
				found_q <= 1'b0;
				for (int k = 0; k < HIST_LEN; k++) begin
					hist_q[k] <= '0;
				end
			end
			cdec_pkg::ST_SCAN_EVAL: begin
				if (hit) begin
					crop_q  <= scol;
					found_q <= 1'b1;
				end else begin
					sum_q     <= sum_q + SUM_W'(avg) - SUM_W'(hist_q[HIST_LEN-1]);
					hist_q[0] <= avg;
					for (int k = 1; k < HIST_LEN; k++) begin
						hist_q[k] <= hist_q[k-1];
					end
					sc_q <= scol;
				end
			end
			cdec_pkg::ST_RESULT: begin
				if (!out_valid_q) begin
					out_crop_q  <= cdec_pkg::CROP_W'(crop_q);
					out_found_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{cdec_pkg::OUT_PAD_W{1'b0}}, out_crop_q};
	assign m_axis_tuser  = out_found_q;

endmodule

`default_nettype wire

>>> test/column_density_edge_crop_unit_tb.sv
module column_density_edge_crop_unit_tb;

	import cdec_pkg::*;

	localparam int unsigned MAX_W         = 4096;
	localparam int unsigned MAX_H         = 4096;
	localparam int unsigned ROW_STEP      = 5;
	localparam int unsigned WINDOW        = 20;
	localparam int unsigned MIN_CROP      = 200;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned END_CYCLES    = 6000;
	localparam int unsigned HOLD_CYCLES   = 15000;
	localparam int unsigned CYCLE_LIMIT   = 8000000;
	localparam int unsigned RANDOM_FRAMES = 40;

	typedef struct packed {
		logic [CROP_W-1:0] crop_width;
		logic              edge_found;
	} crop_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIXEL_W-1:0]    s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	logic [THRESH_W-1:0] threshold_reg = THRESHOLD_RST;
	logic [DIM_W-1:0]    width_reg = WIDTH_RST;
	logic [DIM_W-1:0]    height_reg = HEIGHT_RST;
	int unsigned         bright_count [MAX_W];
	int unsigned         row_idx = 0;
	int unsigned         col_idx = 0;
	crop_result_t        pending_crops [$];

	int unsigned tx_burst_left = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_mode_left = 0;
	int unsigned rx_phase = 0;
	logic        rx_open = 1'b1;
	logic        rx_hold = 1'b0;
	bit          hold_armed = 1'b0;

	column_density_edge_crop_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H),
		.ROW_STEP(ROW_STEP),
		.WINDOW_LENGTH(WINDOW),
		.MIN_CROP(MIN_CROP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[column_density_edge_crop_unit] ERROR");
			$finish;
		end
	end

	function automatic int unsigned active_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (height_reg == 0) return 1;
		if (height_reg > MAX_H) return MAX_H;
		return height_reg;
	endfunction

	function automatic crop_result_t scan_for_edge(input int unsigned w, input int unsigned h);
		crop_result_t res;
		int unsigned  history [WINDOW-1];
		int unsigned  divisor;
		int unsigned  avg;
		int unsigned  sum;
		int unsigned  col;
		res.crop_width = CROP_W'(w);
		res.edge_found = 1'b0;
		foreach (history[k]) history[k] = 0;
		sum = 0;
		divisor = (h + ROW_STEP - 1) / ROW_STEP;
		for (int unsigned c = w; c > MIN_CROP; c--) begin
			col = c - 1;
			avg = bright_count[col] * 255 / divisor;
			if (avg > AVG_MAX) avg = AVG_MAX;
			if (col + 2 * WINDOW < w && (WINDOW - 1) * avg > sum) begin
				res.crop_width = CROP_W'(col);
				res.edge_found = 1'b1;
				return res;
			end
			sum = sum + avg - history[WINDOW-2];
			for (int k = WINDOW - 2; k > 0; k--) history[k] = history[k-1];
			history[0] = avg;
		end
		return res;
	endfunction

	// Returns 1 when this pixel completes the frame and a crop word is due.
	function automatic bit track_pixel(input logic [PIXEL_W-1:0] px, input bit sof,
			output crop_result_t res);
		int unsigned w;
		int unsigned h;
		w = active_width();
		h = active_height();
		res = '0;
		if (sof) begin
			foreach (bright_count[i]) bright_count[i] = 0;
			row_idx = 0;
			col_idx = 0;
		end
		if (row_idx >= h) return 1'b0;
		if (col_idx >= w) begin
			col_idx = 0;
			row_idx++;
			if (row_idx >= h) return 1'b0;
		end
		if (row_idx % ROW_STEP == 0 && px > threshold_reg && col_idx < MAX_W &&
				bright_count[col_idx] < COUNT_MAX) begin
			bright_count[col_idx]++;
		end
		col_idx++;
		if (col_idx >= w) begin
			col_idx = 0;
			row_idx++;
		end
		if (row_idx < h) return 1'b0;
		res = scan_for_edge(w, h);
		return 1'b1;
	endfunction

	function automatic logic [PIXEL_W-1:0] make_pixel(input bit bright);
		if ($urandom_range(0, 24) == 0) return PIXEL_W'($urandom);
		if (!bright) return PIXEL_W'($urandom_range(0, int'(threshold_reg)));
		if (threshold_reg != 8'hFF) return PIXEL_W'($urandom_range(int'(threshold_reg) + 1, 255));
		return PIXEL_W'($urandom);
	endfunction

	task automatic configure(input logic [THRESH_W-1:0] thr, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		reg_idx_t    idx_list [3] = '{REG_THRESHOLD, REG_WIDTH, REG_HEIGHT};
		logic [31:0] val_list [3];
		val_list[0] = 32'(thr);
		val_list[1] = 32'(w);
		val_list[2] = 32'(h);
		for (int i = 0; i < 3; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx_list[i], 2'b00};
			pwdata <= val_list[i];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		threshold_reg = thr;
		width_reg = w;
		height_reg = h;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_crops.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit sof);
		crop_result_t res;
		int unsigned  gap;
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		s_axis_tuser <= sof;
		do @(posedge clk); while (!s_axis_tready);
		tx_burst_left--;
		if (track_pixel(px, sof, res)) pending_crops.push_back(res);
	endtask

	task automatic send_frame(input int unsigned count, input bit sof,
			input int unsigned split_col, input int unsigned left_pct,
			input int unsigned right_pct);
		int unsigned w;
		int unsigned pct;
		w = active_width();
		for (int unsigned i = 0; i < count; i++) begin
			pct = ((i % w) < split_col) ? left_pct : right_pct;
			send_pixel(make_pixel($urandom_range(0, 99) < pct), sof && i == 0);
		end
	endtask

	always @(posedge clk) begin
		crop_result_t want;
		rx_phase++;
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(20, 300);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			RX_OPEN:     rx_open = 1'b1;
			RX_RANDOM:   rx_open = $urandom_range(0, 1);
			RX_SPARSE:   rx_open = ($urandom_range(0, 3) == 0);
			RX_PERIODIC: rx_open = rx_phase[2];
		endcase
		m_axis_tready <= !rx_hold && rx_open;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_crops.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected crop word: crop_width %0d edge_found %0b",
						m_axis_tdata[CROP_W-1:0], m_axis_tuser);
				end
			end else begin
				want = pending_crops.pop_front();
				if (m_axis_tdata[CROP_W-1:0] !== want.crop_width ||
						m_axis_tuser !== want.edge_found) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("crop word mismatch: expected crop_width %0d edge_found %0b, got crop_width %0d edge_found %0b",
							want.crop_width, want.edge_found,
							m_axis_tdata[CROP_W-1:0], m_axis_tuser);
					end
				end
			end
		end
	end

	initial begin
		wait (hold_armed);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// After reset the block counts as if a frame had just started.
	task automatic test_frame_without_start();
		configure(8'd100, 13'd241, 13'd1);
		send_frame(241, 1'b0, 150, 90, 0);
	endtask

	task automatic test_threshold_extremes();
		wait_idle();
		configure(8'd0, 13'd300, 13'd3);
		send_frame(900, 1'b1, 230, 100, 0);
		wait_idle();
		configure(8'd255, 13'd300, 13'd3);
		send_frame(900, 1'b1, 230, 100, 100);
	endtask

	task automatic test_dark_and_bright();
		wait_idle();
		configure(8'd128, 13'd256, 13'd10);
		send_frame(2560, 1'b1, 0, 0, 0);
		send_frame(2560, 1'b1, 0, 100, 100);
	endtask

	task automatic test_rising_edge();
		wait_idle();
		configure(8'd70, 13'd320, 13'd12);
		send_frame(3840, 1'b1, 250, 60, 10);
		send_frame(3840, 1'b1, 270, 95, 0);
	endtask

	task automatic test_narrow_frames();
		int unsigned narrow_w [6] = '{0, 1, 199, 200, 201, 240};
		for (int i = 0; i < 6; i++) begin
			wait_idle();
			configure(8'd50, DIM_W'(narrow_w[i]), DIM_W'(i % 3));
			send_frame(active_width() * active_height(), 1'b1, active_width() / 2, 80, 10);
		end
	endtask

	task automatic test_widest_frames();
		wait_idle();
		configure(8'd30, 13'd4096, 13'd1);
		send_frame(4096, 1'b1, 3000, 100, 0);
		wait_idle();
		configure(8'd200, 13'd8191, 13'd2);
		send_frame(8192, 1'b1, 2048, 50, 50);
	endtask

	task automatic test_ignored_tail();
		wait_idle();
		configure(8'd90, 13'd241, 13'd2);
		send_frame(482, 1'b1, 180, 70, 10);
		send_frame(12, 1'b0, 0, 50, 50);
	endtask

	task automatic test_restart_mid_frame();
		wait_idle();
		configure(8'd60, 13'd241, 13'd4096);
		send_frame(300, 1'b1, 120, 80, 5);
		send_frame(500, 1'b1, 120, 80, 5);
		wait_idle();
		configure(8'd60, 13'd241, 13'd8191);
		send_frame(700, 1'b1, 150, 80, 5);
		wait_idle();
		configure(8'd60, 13'd241, 13'd4);
		send_frame(964, 1'b1, 190, 90, 0);
	endtask

	task automatic test_backpressure();
		wait_idle();
		configure(8'd40, 13'd241, 13'd1);
		hold_armed = 1'b1;
		repeat (4) send_frame(241, 1'b1, $urandom_range(150, 241), 90, 5);
	endtask

	task automatic test_random_frames();
		int unsigned       finished;
		int unsigned       w_raw;
		int unsigned       h_raw;
		int unsigned       cap;
		int unsigned       npix;
		int unsigned       split_col;
		int unsigned       left_pct;
		int unsigned       right_pct;
		int unsigned       sel;
		logic [THRESH_W-1:0] thr;
		finished = 0;
		while (finished < RANDOM_FRAMES) begin
			if (finished == 0 || $urandom_range(0, 99) < 60) begin
				sel = $urandom_range(0, 19);
				if (sel < 14) w_raw = $urandom_range(241, 320);
				else if (sel < 17) w_raw = $urandom_range(321, 1100);
				else if (sel == 17) w_raw = $urandom_range(0, 240);
				else if (sel == 18) w_raw = $urandom_range(4097, 8191);
				else w_raw = $urandom_range(1101, 4096);
				cap = 2600 / ((w_raw == 0) ? 1 : ((w_raw > MAX_W) ? MAX_W : w_raw));
				if (cap == 0) cap = 1;
				if (cap > 30) cap = 30;
				h_raw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, cap);
				if ($urandom_range(0, 4) == 0) thr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else thr = THRESH_W'($urandom);
				wait_idle();
				configure(thr, DIM_W'(w_raw), DIM_W'(h_raw));
			end
			npix = active_width() * active_height();
			split_col = $urandom_range(active_width() / 2, active_width());
			sel = $urandom_range(0, 4);
			if (sel == 0) begin
				left_pct = $urandom_range(0, 100);
				right_pct = left_pct;
			end else if (sel == 4) begin
				left_pct = $urandom_range(0, 1) * 100;
				right_pct = $urandom_range(0, 1) * 100;
			end else begin
				left_pct = $urandom_range(40, 100);
				right_pct = $urandom_range(0, 30);
			end
			if (npix > 1 && $urandom_range(0, 9) == 0) begin
				send_frame($urandom_range(1, npix - 1), 1'b1, split_col, left_pct, right_pct);
			end else begin
				send_frame(npix, 1'b1, split_col, left_pct, right_pct);
				finished++;
				if ($urandom_range(0, 9) == 0) send_frame($urandom_range(1, 16), 1'b0, 0, 50, 50);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_frame_without_start();
		test_threshold_extremes();
		test_dark_and_bright();
		test_rising_edge();
		test_narrow_frames();
		test_widest_frames();
		test_ignored_tail();
		test_restart_mid_frame();
		test_backpressure();
		test_random_frames();
		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_crops.size() == 0) begin
			$display("[column_density_edge_crop_unit] OK");
		end else begin
			$display("[column_density_edge_crop_unit] ERROR");
		end
		$finish;
	end

endmodule
